/* src/bmr_pkg.sv */
// shared types, widths and the entry plan function of the bond matrix block
package bmr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ENT_BITS  = FRAC_BITS + 2;
  localparam int OUT_BITS  = FRAC_BITS + 4;
  localparam int ROW_BITS  = 3 * ENT_BITS;
  localparam int PROD_W    = 2 * ENT_BITS;
  localparam int NUM_ROWS  = 6;
  localparam int NUM_COLS  = 6;
  localparam int NUM_PROD  = 4;

  localparam logic [2:0] LAST_ROW_IDX = 3'(NUM_ROWS - 1);

  typedef logic [ENT_BITS-1:0] ent_t;
  typedef ent_t [2:0][2:0] mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [OUT_BITS-1:0] out_ent_t;

  // one accepted input item, unpacked
  typedef struct packed {
    logic deriv;
    logic inv_t;
    mat_t rm;
    mat_t dm;
  } item_t;

  // the item plus the row currently being produced
  typedef struct packed {
    logic [2:0] row;
    logic       last;
    item_t      item;
  } row_work_t;

  // registered products of one row
  typedef struct packed {
    logic [2:0]                             row;
    logic                                   last;
    logic [NUM_COLS-1:0]                    dbl;
    prod_t [NUM_COLS-1:0][NUM_PROD-1:0]     prods;
  } row_prod_t;

  typedef struct packed {
    logic [2:0]                row;
    logic                      last;
    out_ent_t [NUM_COLS-1:0]   col;
  } row_res_t;

  typedef struct packed {
    logic [1:0] r0;
    logic [1:0] c0;
    logic [1:0] r1;
    logic [1:0] c1;
  } term_idx_t;

  typedef struct packed {
    term_idx_t ta;
    term_idx_t tb;
    logic      two;
    logic      k2;
    logic      k3;
  } entry_plan_t;

  function automatic logic [1:0] pair_a(input logic [1:0] k);
    logic [1:0] v;
    case (k)
      2'd0:    v = 2'd0;
      2'd1:    v = 2'd2;
      2'd2:    v = 2'd1;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pair_b(input logic [1:0] k);
    logic [1:0] v;
    case (k)
      2'd0:    v = 2'd1;
      2'd1:    v = 2'd0;
      2'd2:    v = 2'd2;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

  // which entries of R feed entry (row, col) of the 6x6 matrix
  function automatic entry_plan_t entry_plan(input logic [2:0] row, input logic [2:0] col);
    entry_plan_t p;
    logic [1:0]  i;
    logic [1:0]  j;
    p = '0;
    i = (row >= 3'd3) ? 2'(row - 3'd3) : row[1:0];
    j = (col >= 3'd3) ? 2'(col - 3'd3) : col[1:0];
    if (row < 3'd3 && col < 3'd3) begin
      p.ta = '{r0: i, c0: j, r1: i, c1: j};
    end else if (row < 3'd3) begin
      p.ta = '{r0: i, c0: pair_a(j), r1: i, c1: pair_b(j)};
      p.k2 = 1'b1;
    end else if (col < 3'd3) begin
      p.ta = '{r0: pair_a(i), c0: j, r1: pair_b(i), c1: j};
      p.k3 = 1'b1;
    end else begin
      p.ta  = '{r0: pair_a(i), c0: pair_a(j), r1: pair_b(i), c1: pair_b(j)};
      p.tb  = '{r0: pair_a(i), c0: pair_b(j), r1: pair_b(i), c1: pair_a(j)};
      p.two = 1'b1;
    end
    return p;
  endfunction

endpackage

/* src/bmr_if.sv */
// valid/ready channel interfaces for the input matrices and the result rows
interface bmr_in_if import bmr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [ROW_BITS-1:0] r_row0;
  logic [ROW_BITS-1:0] r_row1;
  logic [ROW_BITS-1:0] r_row2;
  logic [ROW_BITS-1:0] dr_row0;
  logic [ROW_BITS-1:0] dr_row1;
  logic [ROW_BITS-1:0] dr_row2;

  modport source (
    output valid, kind, r_row0, r_row1, r_row2, dr_row0, dr_row1, dr_row2,
    input  ready
  );
  modport sink (
    input  valid, kind, r_row0, r_row1, r_row2, dr_row0, dr_row1, dr_row2,
    output ready
  );
endinterface

interface bmr_out_if import bmr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [2:0]                 row_index;
  logic signed [OUT_BITS-1:0] col0;
  logic signed [OUT_BITS-1:0] col1;
  logic signed [OUT_BITS-1:0] col2;
  logic signed [OUT_BITS-1:0] col3;
  logic signed [OUT_BITS-1:0] col4;
  logic signed [OUT_BITS-1:0] col5;
  logic                       last_row;

  modport source (
    output valid, row_index, col0, col1, col2, col3, col4, col5, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col0, col1, col2, col3, col4, col5, last_row,
    output ready
  );
endinterface

/* src/bond_matrix_3d_rotation.sv */
// top level of the 6x6 bond transformation matrix generator
//
// in_ch_i carries one 3x3 rotation matrix R, its derivative dR and a kind
// code (bond, inverse transpose, or the derivative of either). For every
// input transfer the block returns six transfers on out_ch_o, the rows of
// the 6x6 Voigt matrix in order 0 to 5, with last_row set on row 5.
// Entries are Q3.16, rounded to nearest (ties up) and saturated.
//
// Throughput: one result row per cycle while out_ch_o.ready is high; the
// single result channel carrying six rows per item sets that rate.
// Path: a taken item enters the item register; each row then passes
// operand select and products into the product register, then sum, round
// and saturate into the result register. The next item is taken in the
// cycle row 5 leaves the item register, so items stream with no gap on the output.
//
// Reset clears all valid flags and the row counter; the data registers are
// not reset. A stalled receiver holds the result register, back pressure
// fills the product stage, and in_ch_i.ready drops until the rows drain.
module bond_matrix_3d_rotation import bmr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bmr_in_if.sink        in_ch_i,
  bmr_out_if.source     out_ch_o
);

  item_t     in_item;
  row_work_t work;
  logic      work_valid;
  logic      work_ready;
  row_prod_t prod;
  logic      prod_valid;
  logic      prod_ready;
  row_res_t  res;

  always_comb begin
    in_item.deriv = in_ch_i.kind[1];
    in_item.inv_t = in_ch_i.kind[0];
    for (int c = 0; c < 3; c++) begin
      in_item.rm[0][c] = in_ch_i.r_row0[c*ENT_BITS +: ENT_BITS];
      in_item.rm[1][c] = in_ch_i.r_row1[c*ENT_BITS +: ENT_BITS];
      in_item.rm[2][c] = in_ch_i.r_row2[c*ENT_BITS +: ENT_BITS];
      in_item.dm[0][c] = in_ch_i.dr_row0[c*ENT_BITS +: ENT_BITS];
      in_item.dm[1][c] = in_ch_i.dr_row1[c*ENT_BITS +: ENT_BITS];
      in_item.dm[2][c] = in_ch_i.dr_row2[c*ENT_BITS +: ENT_BITS];
    end
  end

  bmr_row_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch_i.valid),
    .in_ready_o   (in_ch_i.ready),
    .in_item_i    (in_item),
    .work_valid_o (work_valid),
    .work_ready_i (work_ready),
    .work_o       (work)
  );

  bmr_prod u_prod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_ready_o (work_ready),
    .work_i       (work),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  bmr_round u_round (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .res_valid_o  (out_ch_o.valid),
    .res_ready_i  (out_ch_o.ready),
    .res_o        (res)
  );

  assign out_ch_o.row_index = res.row;
  assign out_ch_o.last_row  = res.last;
  assign out_ch_o.col0      = res.col[0];
  assign out_ch_o.col1      = res.col[1];
  assign out_ch_o.col2      = res.col[2];
  assign out_ch_o.col3      = res.col[3];
  assign out_ch_o.col4      = res.col[4];
  assign out_ch_o.col5      = res.col[5];

endmodule

/* src/bmr_row_seq.sv */
// input item register and row counter, one row handed on per cycle while the product stage is ready
module bmr_row_seq import bmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  item_t     in_item_i,
  output logic      work_valid_o,
  input  logic      work_ready_i,
  output row_work_t work_o
);

  item_t      item_q;
  logic       item_v_q;
  logic [2:0] row_q;
  logic       in_xfer;
  logic       emit;

  assign emit       = item_v_q && work_ready_i;
  assign in_ready_o = !item_v_q || (work_ready_i && row_q == LAST_ROW_IDX);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      row_q    <= '0;
    end else if (in_xfer) begin
      item_v_q <= 1'b1;
      row_q    <= '0;
    end else if (emit) begin
      if (row_q == LAST_ROW_IDX) begin
        item_v_q <= 1'b0;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
  end

  assign work_valid_o = item_v_q;
  assign work_o.row   = row_q;
  assign work_o.last  = (row_q == LAST_ROW_IDX);
  assign work_o.item  = item_q;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_v_q |-> row_q <= LAST_ROW_IDX)
    else $error("row counter out of range");

  a_new_item_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> item_v_q && row_q == 3'd0)
    else $error("new item does not start at row 0");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && row_q != LAST_ROW_IDX) |=> item_v_q && row_q == $past(row_q) + 3'd1)
    else $error("row counter skipped a row");

endmodule

/* src/bmr_prod.sv */
// product stage: selects operands for one row and registers all its products
module bmr_prod import bmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  row_work_t work_i,
  output logic      prod_valid_o,
  input  logic      prod_ready_i,
  output row_prod_t prod_o
);

  row_prod_t prod_d;
  row_prod_t prod_q;
  logic      prod_v_q;
  logic      adv;

  assign adv          = !prod_v_q || prod_ready_i;
  assign work_ready_o = adv;

  always_comb begin
    entry_plan_t p;
    ent_t        a [NUM_PROD];
    ent_t        b [NUM_PROD];
    prod_d.row  = work_i.row;
    prod_d.last = work_i.last;
    for (int c = 0; c < NUM_COLS; c++) begin
      p = entry_plan(work_i.row, 3'(c));
      // product rule: x*y becomes x*dy + dx*y
      a[0] = work_i.item.rm[p.ta.r0][p.ta.c0];
      b[0] = work_i.item.deriv ? work_i.item.dm[p.ta.r1][p.ta.c1]
                               : work_i.item.rm[p.ta.r1][p.ta.c1];
      a[1] = work_i.item.deriv ? work_i.item.dm[p.ta.r0][p.ta.c0] : '0;
      b[1] = work_i.item.rm[p.ta.r1][p.ta.c1];
      a[2] = p.two ? work_i.item.rm[p.tb.r0][p.tb.c0] : '0;
      b[2] = work_i.item.deriv ? work_i.item.dm[p.tb.r1][p.tb.c1]
                               : work_i.item.rm[p.tb.r1][p.tb.c1];
      a[3] = (p.two && work_i.item.deriv) ? work_i.item.dm[p.tb.r0][p.tb.c0] : '0;
      b[3] = work_i.item.rm[p.tb.r1][p.tb.c1];
      for (int k = 0; k < NUM_PROD; k++) begin
        prod_d.prods[c][k] = PROD_W'($signed(a[k])) * PROD_W'($signed(b[k]));
      end
      prod_d.dbl[c] = work_i.item.inv_t ? p.k3 : p.k2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (adv) begin
      prod_v_q <= work_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && work_valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_v_q;
  assign prod_o       = prod_q;

endmodule

/* src/bmr_round.sv */
// sum, doubling, round to nearest and saturation into the result register
module bmr_round import bmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      prod_valid_i,
  output logic      prod_ready_o,
  input  row_prod_t prod_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output row_res_t  res_o
);

  localparam int SUM_W = PROD_W + 2;
  localparam int DBL_W = SUM_W + 1;
  localparam int RND_W = DBL_W + 1;
  localparam int Q_W   = RND_W - FRAC_BITS;

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0]   Q_MIN    = -Q_MAX - Q_W'(1);

  row_res_t res_d;
  row_res_t res_q;
  logic     res_v_q;
  logic     adv;

  logic signed [SUM_W-1:0] sum   [NUM_COLS];
  logic signed [DBL_W-1:0] dsum  [NUM_COLS];
  logic signed [RND_W-1:0] rsum  [NUM_COLS];
  logic signed [Q_W-1:0]   qval  [NUM_COLS];

  assign adv          = !res_v_q || res_ready_i;
  assign prod_ready_o = adv;

  always_comb begin
    res_d.row  = prod_i.row;
    res_d.last = prod_i.last;
    for (int c = 0; c < NUM_COLS; c++) begin
      sum[c] = SUM_W'($signed(prod_i.prods[c][0])) + SUM_W'($signed(prod_i.prods[c][1]))
             + SUM_W'($signed(prod_i.prods[c][2])) + SUM_W'($signed(prod_i.prods[c][3]));
      dsum[c] = prod_i.dbl[c] ? (DBL_W'(sum[c]) <<< 1) : DBL_W'(sum[c]);
      // ties go toward plus infinity
      rsum[c] = RND_W'(dsum[c]) + RND_HALF;
      qval[c] = $signed(rsum[c][RND_W-1:FRAC_BITS]);
      if (qval[c] > Q_MAX) begin
        res_d.col[c] = OUT_BITS'(Q_MAX);
      end else if (qval[c] < Q_MIN) begin
        res_d.col[c] = OUT_BITS'(Q_MIN);
      end else begin
        res_d.col[c] = OUT_BITS'(qval[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (adv) begin
      res_v_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && prod_valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
